// File: design/encoder_speed_pi_regulator_defines.svh
// Assertion macros shared by the encoder speed PI regulator RTL.
`ifndef ENCODER_SPEED_PI_REGULATOR_DEFINES_SVH
`define ENCODER_SPEED_PI_REGULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ESPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/espi_pkg.sv
// Types, constants and saturation helpers for the encoder speed PI regulator.
package espi_pkg;

  localparam int POS_W   = 12;
  localparam int SETP_W  = 21;
  localparam int ERR_W   = 22;
  localparam int DRV_W   = 22;
  localparam int GAIN_W  = 12;
  localparam int RATE_W  = 14;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 2;
  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 14;
  localparam int PROD_W  = 37;
  localparam int ACC_W   = 32;

  localparam int COUNTS_PER_TURN = 4096;
  localparam int WRAP_THRESHOLD  = 1000;
  localparam int SPEED_SHIFT     = 12;
  localparam int DRV_SHIFT       = 10;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_KI   = 2'd0;
  localparam logic [IDX_W-1:0] REG_KP   = 2'd1;
  localparam logic [IDX_W-1:0] REG_RATE = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SPD  = 6'b000010,
    ST_ERR  = 6'b000100,
    ST_IMUL = 6'b001000,
    ST_IACC = 6'b010000,
    ST_DRV  = 6'b100000
  } espi_state_t;

  // Clamp a 38-bit signed sum to the signed 32-bit range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [37:0] v);
    logic signed [37:0] hi;
    logic signed [37:0] lo;
    hi = 38'sh0_7FFF_FFFF;
    lo = -38'sh0_8000_0000;
    if (v > hi) begin
      sat_acc = ACC_W'(hi);
    end else if (v < lo) begin
      sat_acc = ACC_W'(lo);
    end else begin
      sat_acc = v[ACC_W-1:0];
    end
  endfunction

  // Clamp a 26-bit signed difference to the signed 22-bit error range.
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [25:0] v);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sd2097151;
    lo = -26'sd2097152;
    if (v > hi) begin
      sat_err = ERR_W'(hi);
    end else if (v < lo) begin
      sat_err = ERR_W'(lo);
    end else begin
      sat_err = v[ERR_W-1:0];
    end
  endfunction

endpackage

// File: design/encoder_speed_pi_regulator.sv
// Encoder speed estimate and PI speed regulator on one shared multiplier.
// A transaction steps through the speed, error, Ki multiply, integrator and drive states.
// The single 22x14 multiplier is used three times per transaction; a new one waits for idle.
// The input is stalled from acceptance until the result is loaded into the output register.
// Reset (rst_n low, synchronous) clears the gains, sets the sample rate to 1000,
// and zeroes the previous position and the integrator; no clearing pass is needed.
module encoder_speed_pi_regulator
  import espi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [POS_W-1:0]         in_encoder_position,
  input  logic signed [SETP_W-1:0] in_speed_setpoint,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ERR_W-1:0]  out_speed_error,
  output logic signed [DRV_W-1:0]  out_drive_value
);

`include "encoder_speed_pi_regulator_defines.svh"

  // Control and state registers.
  espi_state_t               state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0]         ki_r;
  logic [GAIN_W-1:0]         kp_r;
  logic [RATE_W-1:0]         rate_r;
  logic [POS_W-1:0]          prev_pos_r, prev_pos_nxt;
  logic signed [ACC_W-1:0]   integ_r, integ_nxt;

  // Datapath registers that carry one transaction through the sequence.
  logic signed [19:0]        d60_r, d60_nxt;
  logic signed [SETP_W-1:0]  setp_r, setp_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ERR_W-1:0]   out_err_r, out_err_nxt;
  logic signed [DRV_W-1:0]   out_drv_r, out_drv_nxt;

  // Shared multiplier: signed 22-bit operand times unsigned 14-bit operand.
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic                      in_take;
  logic                      out_free;
  logic signed [13:0]        raw_diff;
  logic signed [13:0]        diff;
  logic signed [PROD_W-SPEED_SHIFT-1:0] speed;
  logic signed [25:0]        err_full;
  logic signed [37:0]        acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [ACC_W:0]     drv_round;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_speed_error = out_err_r;
  assign out_drive_value = out_drv_r;

  // This is the only multiplier in the block; its result always lands in prod_r.
  assign mul_p = $signed({{(PROD_W-MUL_A_W){mul_a[MUL_A_W-1]}}, mul_a})
               * $signed({{(PROD_W-MUL_B_W){1'b0}}, mul_b});

  // Position difference against the last sample, folded back by one turn across the wrap.
  assign raw_diff = $signed({2'b00, in_encoder_position}) - $signed({2'b00, prev_pos_r});
  always_comb begin
    diff = raw_diff;
    if (raw_diff > 14'(WRAP_THRESHOLD) || raw_diff < -14'(WRAP_THRESHOLD)) begin
      if (raw_diff < 0) begin
        diff = raw_diff + 14'(COUNTS_PER_TURN);
      end else begin
        diff = raw_diff - 14'(COUNTS_PER_TURN);
      end
    end
  end

  // Speed is floor(diff * 60 * rate / 4096), an arithmetic shift of the product.
  assign speed    = prod_r[PROD_W-1:SPEED_SHIFT];
  assign err_full = $signed({{5{setp_r[SETP_W-1]}}, setp_r}) - 26'(speed);

  // One adder serves both the integrator update and the drive sum.
  assign acc_sum  = $signed({{6{integ_r[ACC_W-1]}}, integ_r}) + 38'(prod_r);
  assign acc_sat  = sat_acc(acc_sum);

  // Divide by 1024 truncating toward zero: bias negative values before the shift.
  assign drv_round = $signed({acc_sat[ACC_W-1], acc_sat})
                   + (acc_sat[ACC_W-1] ? 33'sd1023 : 33'sd0);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    prev_pos_nxt  = prev_pos_r;
    integ_nxt     = integ_r;
    d60_nxt       = d60_r;
    setp_nxt      = setp_r;
    prod_nxt      = prod_r;
    err_nxt       = err_r;
    out_err_nxt   = out_err_r;
    out_drv_nxt   = out_drv_r;
    mul_a         = err_r;
    mul_b         = {{(MUL_B_W-GAIN_W){1'b0}}, ki_r};

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          prev_pos_nxt = in_encoder_position;
          setp_nxt     = in_speed_setpoint;
          // Times 60 as 64x minus 4x.
          d60_nxt      = ($signed({{6{diff[13]}}, diff}) <<< 6)
                       - ($signed({{6{diff[13]}}, diff}) <<< 2);
          state_nxt    = ST_SPD;
        end
      end
      ST_SPD: begin
        mul_a     = {{(MUL_A_W-20){d60_r[19]}}, d60_r};
        mul_b     = rate_r;
        prod_nxt  = mul_p;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        err_nxt   = sat_err(err_full);
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        mul_a     = err_r;
        mul_b     = {{(MUL_B_W-GAIN_W){1'b0}}, ki_r};
        prod_nxt  = mul_p;
        state_nxt = ST_IACC;
      end
      ST_IACC: begin
        // Integrator update and the proportional product share this cycle.
        integ_nxt = acc_sat;
        mul_a     = err_r;
        mul_b     = {{(MUL_B_W-GAIN_W){1'b0}}, kp_r};
        prod_nxt  = mul_p;
        state_nxt = ST_DRV;
      end
      ST_DRV: begin
        // Hold here until the output register is free to take the result.
        if (out_free) begin
          out_err_nxt   = err_r;
          out_drv_nxt   = drv_round[ACC_W-1:DRV_SHIFT];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ki_r        <= '0;
      kp_r        <= '0;
      rate_r      <= RATE_RESET;
      prev_pos_r  <= '0;
      integ_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_pos_r  <= prev_pos_nxt;
      integ_r     <= integ_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KI:   ki_r   <= cfg_wdata[GAIN_W-1:0];
          REG_KP:   kp_r   <= cfg_wdata[GAIN_W-1:0];
          REG_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    d60_r     <= d60_nxt;
    setp_r    <= setp_nxt;
    prod_r    <= prod_nxt;
    err_r     <= err_nxt;
    out_err_r <= out_err_nxt;
    out_drv_r <= out_drv_nxt;
  end

  // An accepted transaction keeps the input stalled in the following cycle.
  `ESPI_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, in_stall,
                    "input not stalled after a transaction was accepted")

  // A new result appears only when the sequence finishes its drive step.
  `ESPI_ASSERT_NOW(a_result_from_drive, clk, rst_n, $rose(out_valid_r),
                   $past(state_r) == ST_DRV, "result valid rose outside the drive step")

  // When the drive step finds the output free, the result is posted and the input reopens.
  `ESPI_ASSERT_NEXT(a_drive_completes, clk, rst_n, (state_r == ST_DRV) && out_free,
                    out_valid_r && !in_stall, "drive step did not post its result")

endmodule

// File: tb/encoder_speed_pi_regulator_test.sv
// Self-checking testbench for the encoder speed PI regulator.
module encoder_speed_pi_regulator_test
  import espi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The last index of the 2-bit register space is not mapped to any register.
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Most negative setpoint that the 21-bit field can carry.
  localparam logic signed [SETP_W-1:0] SETP_MIN = {1'b1, {(SETP_W-1){1'b0}}};

  // Clamp bounds of the error and of the integrator and drive accumulators.
  localparam longint ERR_LO = -64'sd2097152;
  localparam longint ERR_HI = 64'sd2097151;
  localparam longint ACC_LO = -64'sd2147483648;
  localparam longint ACC_HI = 64'sd2147483647;

  // The block is back in idle once its last result has been taken, so these
  // extra cycles only make sure that it has settled.
  localparam int SETTLE_CYCLES = 8;
  // Longest legal quiet stretch is the long receiver hold-off below plus a
  // few gaps and pipeline cycles; the limit is several times that.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 6;
  localparam int SAMPLES_PER_PHASE = 125;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [POS_W-1:0]         in_encoder_position;
  logic signed [SETP_W-1:0] in_speed_setpoint;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ERR_W-1:0]  out_speed_error;
  logic signed [DRV_W-1:0]  out_drive_value;

  // One expected result transaction.
  typedef struct {
    logic signed [ERR_W-1:0] speed_error;
    logic signed [DRV_W-1:0] drive_value;
  } regulator_out_t;

  regulator_out_t regulator_outputs_q[$];

  // Shadow copy of the configuration and of the regulator state.
  logic [GAIN_W-1:0] ki_gain;
  logic [GAIN_W-1:0] kp_gain;
  logic [RATE_W-1:0] rate_sps;
  logic [POS_W-1:0]  last_position;
  longint            integ_acc;

  // Position of the last sample sent, used to build plausible motion.
  logic [POS_W-1:0] sent_position;

  bit gaps_enabled;
  int receiver_hold;
  int failures;
  int samples_sent;
  int results_checked;
  int reg_writes;
  int hold_offs;

  encoder_speed_pi_regulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_encoder_position (in_encoder_position),
    .in_speed_setpoint   (in_speed_setpoint),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_speed_error     (out_speed_error),
    .out_drive_value     (out_drive_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Work out the result of one sample and advance the shadow state. The
  // speed estimate floors diff * 60 * rate / 4096, which an arithmetic
  // shift of the signed product gives exactly.
  function automatic void regulate_sample(input logic [POS_W-1:0] pos,
                                          input logic signed [SETP_W-1:0] setp);
    longint delta;
    longint speed;
    longint err;
    longint drive;
    regulator_out_t r;
    delta = longint'(pos) - longint'(last_position);
    last_position = pos;
    // A jump larger than the threshold is taken as a wrap through zero.
    if (delta > WRAP_THRESHOLD) begin
      delta = delta - COUNTS_PER_TURN;
    end else if (delta < -WRAP_THRESHOLD) begin
      delta = delta + COUNTS_PER_TURN;
    end
    speed = (delta * 60 * longint'(rate_sps)) >>> SPEED_SHIFT;
    err   = clamp_to(longint'(setp) - speed, ERR_LO, ERR_HI);
    integ_acc = clamp_to(integ_acc + longint'(ki_gain) * err, ACC_LO, ACC_HI);
    drive = clamp_to(err * longint'(kp_gain) + integ_acc, ACC_LO, ACC_HI);
    // Division by 1024 truncates toward zero, unlike the speed shift.
    r.speed_error = ERR_W'(err);
    r.drive_value = DRV_W'(drive / 1024);
    regulator_outputs_q.push_back(r);
  endfunction

  // Offer one sample after a random gap and hold it until it is accepted.
  // Valid is only lowered when a gap follows, so back-to-back transactions
  // never see valid dropped and raised in the same time step.
  task automatic send_sample(input logic [POS_W-1:0] pos,
                             input logic signed [SETP_W-1:0] setp);
    int gap;
    gap = gaps_enabled ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_encoder_position <= pos;
    in_speed_setpoint   <= setp;
    do @(posedge clk); while (in_stall !== 1'b0);
    regulate_sample(pos, setp);
    sent_position = pos;
    samples_sent++;
  endtask

  // Stop offering, let every expected result arrive, then let the block settle.
  task automatic wait_for_outputs();
    in_valid <= 1'b0;
    while (regulator_outputs_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the task returns with the enable already low, so
  // that the enable is never dropped and raised in one time step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_KI:   ki_gain  = data[GAIN_W-1:0];
      REG_KP:   kp_gain  = data[GAIN_W-1:0];
      REG_RATE: rate_sps = data[RATE_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom_range(0, 31));
      default: return GAIN_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return RATE_W'(1);
      1:       return '1;
      2:       return RATE_W'(1000);
      3:       return '0;
      default: return RATE_W'($urandom_range(1, 16383));
    endcase
  endfunction

  // Mostly smooth motion with modest setpoints, so the integrator spends
  // time away from its rails; the rest are jumps around the wrap threshold,
  // arbitrary positions and full-range setpoints.
  task automatic send_random_sample();
    logic [POS_W-1:0]         pos;
    logic signed [SETP_W-1:0] setp;
    int step;
    int value;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        step = $urandom_range(0, 40);
        pos  = sent_position + POS_W'(step - 20);
      end
      3, 4, 5, 6: begin
        step = $urandom_range(0, 1800);
        pos  = sent_position + POS_W'(step - 900);
      end
      7, 8: begin
        step = $urandom_range(998, 1003);
        if ($urandom_range(0, 1) == 1) step = -step;
        pos = sent_position + POS_W'(step);
      end
      default: pos = POS_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        value = $urandom_range(0, 6000);
        setp  = SETP_W'(value - 3000);
      end
      5, 6, 7: begin
        value = $urandom_range(0, 1200000);
        setp  = SETP_W'(value - 600000);
      end
      default: setp = SETP_W'($urandom);
    endcase
    send_sample(pos, setp);
  endtask

  // Default registers after reset: zero gains, so only the speed estimate
  // and the error are live. The first sample is taken against position
  // zero, and the wrap threshold is probed on both sides in both directions.
  task automatic test_reset_defaults();
    send_sample(12'd4095, 21'sd0);
    send_sample(12'd0,    21'sd1048575);
    send_sample(12'd1000, SETP_MIN);
    send_sample(12'd0,    21'sd1);
    send_sample(12'd1001, -21'sd1);
    send_sample(12'd0,    21'sd600000);
    send_sample(12'd2048, -21'sd600000);
    send_sample(12'd2048, 21'sd0);
    wait_for_outputs();
  endtask

  // Largest gains and rate drive the integrator and the drive into both
  // rails. A zero rate then kills the speed estimate, a write to the unmapped
  // index must change nothing, and gain writes with the upper data bits set
  // must keep only the low twelve.
  task automatic test_gain_extremes();
    write_reg(REG_KI, '1);
    write_reg(REG_KP, '1);
    write_reg(REG_RATE, '1);
    send_sample(12'd2948, 21'sd1048575);
    send_sample(12'd3948, 21'sd1048575);
    send_sample(12'd3948, 21'sd1048575);
    send_sample(12'd2948, SETP_MIN);
    send_sample(12'd1948, SETP_MIN);
    send_sample(12'd1948, SETP_MIN);
    wait_for_outputs();
    write_reg(REG_RATE, '0);
    write_reg(REG_UNMAPPED, 14'h2AAA);
    send_sample(12'd2900, 21'sd300);
    send_sample(12'd1950, -21'sd300);
    wait_for_outputs();
    write_reg(REG_KI, 14'h3001);
    write_reg(REG_KP, 14'h2002);
    write_reg(REG_RATE, 14'd1);
    send_sample(12'd2500, 21'sd5);
    send_sample(12'd2400, -21'sd5);
    wait_for_outputs();
  endtask

  // Random phases, each with its own register setting; every other phase
  // runs without idling on either side.
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_outputs();
      write_reg(REG_KI, {(CFG_W-GAIN_W)'($urandom_range(0, 3)), pick_gain()});
      write_reg(REG_KP, {(CFG_W-GAIN_W)'($urandom_range(0, 3)), pick_gain()});
      write_reg(REG_RATE, pick_rate());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, CFG_W'($urandom));
      gaps_enabled = (p % 2 == 0);
      for (int i = 0; i < SAMPLES_PER_PHASE; i++) send_random_sample();
    end
    wait_for_outputs();
    gaps_enabled = 1'b1;
  endtask

  // The receiver holds off for a long stretch while samples keep coming
  // back to back, so the output register fills and the input stalls.
  task automatic test_backpressure();
    wait_for_outputs();
    write_reg(REG_KI, 14'd3);
    write_reg(REG_KP, 14'd700);
    write_reg(REG_RATE, 14'd1000);
    gaps_enabled  = 1'b0;
    receiver_hold = HOLD_OFF_CYCLES;
    for (int i = 0; i < 24; i++) send_random_sample();
    wait_for_outputs();
    gaps_enabled = 1'b1;
  endtask

  // Result sink: a random stall ahead of each result, or the long hold-off
  // when one has been requested.
  initial begin : result_sink
    int pause;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (receiver_hold > 0) begin
        pause = receiver_hold;
        receiver_hold = 0;
        hold_offs++;
      end else begin
        pause = gaps_enabled ? $urandom_range(0, 13) : 0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    regulator_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (regulator_outputs_q.size() == 0) begin
        $error("result transaction with no sample outstanding: error %0d, drive %0d",
               out_speed_error, out_drive_value);
        failures++;
      end else begin
        want = regulator_outputs_q.pop_front();
        results_checked++;
        if (out_speed_error !== want.speed_error) begin
          $error("speed_error mismatch: expected %0d, actual %0d",
                 want.speed_error, out_speed_error);
          failures++;
        end
        if (out_drive_value !== want.drive_value) begin
          $error("drive_value mismatch: expected %0d, actual %0d",
                 want.drive_value, out_drive_value);
          failures++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : run
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= '0;
    cfg_wdata           <= '0;
    in_valid            <= 1'b0;
    in_encoder_position <= '0;
    in_speed_setpoint   <= '0;
    ki_gain         = '0;
    kp_gain         = '0;
    rate_sps        = RATE_RESET;
    last_position   = '0;
    integ_acc       = 0;
    sent_position   = '0;
    gaps_enabled    = 1'b1;
    receiver_hold   = 0;
    failures        = 0;
    samples_sent    = 0;
    results_checked = 0;
    reg_writes      = 0;
    hold_offs       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_gain_extremes();
    test_random_phases();
    test_backpressure();
    wait_for_outputs();

    if (regulator_outputs_q.size() != 0) begin
      $error("%0d expected results never arrived", regulator_outputs_q.size());
      failures++;
    end
    $display("Ran %0d samples and checked %0d results over %0d register writes,",
             samples_sent, results_checked, reg_writes);
    $display("covering wrap, rail saturation, zero rate and %0d long output hold-off(s).",
             hold_offs);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/espi_pkg.sv
design/encoder_speed_pi_regulator.sv
tb/encoder_speed_pi_regulator_test.sv
